// ----- design/ack_sequence_reorder_window_top_assert.svh -----
// ----------------------------------------------------------------------------
// ack sequence reorder window assertion macros
// shared property forms for the reorder window checks
// ----------------------------------------------------------------------------
`ifndef ACK_SEQUENCE_REORDER_WINDOW_TOP_ASSERT_SVH
`define ACK_SEQUENCE_REORDER_WINDOW_TOP_ASSERT_SVH

// same-cycle implication
`define ASRW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASRW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/asrw_pkg.sv -----
// ----------------------------------------------------------------------------
// asrw_pkg
// shared types, constants and helpers of the reorder window
// ----------------------------------------------------------------------------
package asrw_pkg;

  localparam int CLIENTS = 8;
  localparam int WINDOW  = 3;
  localparam int SLOT_W  = 3;
  localparam int POS_W   = $clog2(WINDOW);
  localparam int CNT_W   = $clog2(WINDOW + 1);

  localparam logic [2:0] ACT_RECV  = 3'd0;
  localparam logic [2:0] ACT_JOIN  = 3'd1;
  localparam logic [2:0] ACT_LEAVE = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_QUERY = 3'd4;

  localparam logic [2:0] KIND_RECV   = 3'd0;
  localparam logic [2:0] KIND_DELIV  = 3'd1;
  localparam logic [2:0] KIND_STATUS = 3'd2;
  localparam logic [2:0] KIND_QUERY  = 3'd3;
  localparam logic [2:0] KIND_JOIN   = 3'd4;
  localparam logic [2:0] KIND_ROUND  = 3'd5;

  localparam logic [2:0] CODE_INSERTED = 3'd0;
  localparam logic [2:0] CODE_SHORT    = 3'd1;
  localparam logic [2:0] CODE_AHEAD    = 3'd2;
  localparam logic [2:0] CODE_STALE    = 3'd3;
  localparam logic [2:0] CODE_DUP      = 3'd4;
  localparam logic [2:0] CODE_OLDEST   = 3'd5;
  localparam logic [2:0] CODE_EVICTED  = 3'd6;

  localparam logic [14:0] SUSPEND_RESET = 15'd20;
  localparam logic [14:0] DROP_RESET    = 15'd1200;

  localparam logic REG_SUSPEND = 1'b0;
  localparam logic REG_DROP    = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_EXEC,
    OP_TSTAT,
    OP_TDELIV,
    OP_TDONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [2:0] action;
  } sts_t;

  // serial arithmetic: a is older than b
  function automatic logic older(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return d[15];
  endfunction

endpackage

// ----- design/asrw_datapath.sv -----
// ----------------------------------------------------------------------------
// asrw_datapath
// client state, sorted windows, sequence counter and result register
// ----------------------------------------------------------------------------
module asrw_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  asrw_pkg::cmd_t       cmd,
  output asrw_pkg::sts_t       sts,
  input  logic [2:0]           in_action,
  input  logic [2:0]           in_client,
  input  logic [15:0]          in_ack_number,
  input  logic                 in_long_enough,
  input  logic [7:0]           in_handle,
  input  logic [15:0]          in_query_number,
  input  logic [14:0]          suspend_rounds,
  input  logic [14:0]          drop_rounds,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_kind,
  output logic [2:0]           out_client_slot,
  output logic [2:0]           out_code,
  output logic [7:0]           out_packet_handle,
  output logic                 out_evicted_valid,
  output logic [7:0]           out_evicted_handle,
  output logic                 out_suspended,
  output logic                 out_dropped,
  output logic                 out_acked,
  output logic [15:0]          out_sequence_res,
  output logic                 out_last
);

  logic                       valid_r  [asrw_pkg::CLIENTS];
  logic [15:0]                lack_r   [asrw_pkg::CLIENTS];
  logic [asrw_pkg::CNT_W-1:0] wcnt_r   [asrw_pkg::CLIENTS];
  logic [15:0]                wack_r   [asrw_pkg::CLIENTS][asrw_pkg::WINDOW];
  logic [7:0]                 whand_r  [asrw_pkg::CLIENTS][asrw_pkg::WINDOW];
  logic [15:0]                seq_r;

  logic [2:0]  act_r;
  logic [2:0]  cl_r;
  logic [15:0] b_r;
  logic        long_r;
  logic [7:0]  h_r;
  logic [15:0] q_r;

  logic        ov_r;
  logic [2:0]  o_kind_r, o_slot_r, o_code_r;
  logic [7:0]  o_ph_r, o_eh_r;
  logic        o_ev_r, o_sus_r, o_drp_r, o_ack_r, o_last_r;
  logic [15:0] o_seq_r;

  logic        out_free;
  logic        emit;
  logic        slot_ok;
  logic [15:0] ra [asrw_pkg::WINDOW];
  logic [7:0]  rh [asrw_pkg::WINDOW];
  logic [15:0] na [asrw_pkg::WINDOW];
  logic [7:0]  nh [asrw_pkg::WINDOW];
  logic [asrw_pkg::CNT_W-1:0] rcnt;
  logic [asrw_pkg::CNT_W-1:0] pos;
  logic [asrw_pkg::CNT_W-1:0] jj;
  logic        found;
  logic [2:0]  rcode;
  logic        rev;
  logic [7:0]  reh;
  logic        rwrite;
  logic        rgrow;

  logic [asrw_pkg::CNT_W-1:0] tcnt;
  logic [asrw_pkg::CNT_W-1:0] tcm1;
  logic [15:0] tla;
  logic        tdrop, tsus;
  logic        dhit;
  logic        qack;

  assign out_free = !ov_r || out_ready;
  assign sts.out_free = out_free;
  assign sts.action   = act_r;
  assign slot_ok = ({1'b0, cl_r} < 4'(asrw_pkg::CLIENTS));

  // a new result is loaded into the output register this cycle
  assign emit = (cmd.op == asrw_pkg::OP_EXEC) ||
                ((cmd.op == asrw_pkg::OP_TSTAT) && valid_r[cmd.slot]) ||
                ((cmd.op == asrw_pkg::OP_TDELIV) && dhit) ||
                (cmd.op == asrw_pkg::OP_TDONE);

  // receive: locate, classify and build the new window row
  always_comb begin
    rcnt  = wcnt_r[cl_r];
    pos   = rcnt;
    found = 1'b0;
    for (int k = 0; k < asrw_pkg::WINDOW; k++) begin
      ra[k] = wack_r[cl_r][k];
      rh[k] = whand_r[cl_r][k];
    end
    for (int k = 0; k < asrw_pkg::WINDOW; k++) begin
      if (!found && (asrw_pkg::CNT_W'(k) < rcnt) && !asrw_pkg::older(ra[k], b_r)) begin
        pos   = asrw_pkg::CNT_W'(k);
        found = 1'b1;
      end
    end
    jj     = pos - 1'b1;
    rev    = 1'b0;
    reh    = h_r;
    rwrite = 1'b0;
    rgrow  = 1'b0;
    for (int k = 0; k < asrw_pkg::WINDOW; k++) begin
      na[k] = ra[k];
      nh[k] = rh[k];
    end
    if (!slot_ok || !valid_r[cl_r]) begin
      rcode = asrw_pkg::CODE_STALE;
    end else if (!long_r) begin
      rcode = asrw_pkg::CODE_SHORT;
    end else if (asrw_pkg::older(seq_r, b_r)) begin
      rcode = asrw_pkg::CODE_AHEAD;
    end else if (!asrw_pkg::older(lack_r[cl_r], b_r)) begin
      rcode = asrw_pkg::CODE_STALE;
    end else if (found && (ra[pos[asrw_pkg::POS_W-1:0]] == b_r)) begin
      rcode = asrw_pkg::CODE_DUP;
    end else if (rcnt < asrw_pkg::CNT_W'(asrw_pkg::WINDOW)) begin
      rcode  = asrw_pkg::CODE_INSERTED;
      reh    = 8'd0;
      rwrite = 1'b1;
      rgrow  = 1'b1;
      for (int k = 0; k < asrw_pkg::WINDOW; k++) begin
        if (asrw_pkg::CNT_W'(k) == pos) begin
          na[k] = b_r;
          nh[k] = h_r;
        end else if ((k > 0) && (asrw_pkg::CNT_W'(k) > pos)) begin
          na[k] = ra[(k > 0) ? k - 1 : 0];
          nh[k] = rh[(k > 0) ? k - 1 : 0];
        end
      end
    end else if (pos == '0) begin
      rcode = asrw_pkg::CODE_OLDEST;
    end else begin
      rcode  = asrw_pkg::CODE_EVICTED;
      rev    = 1'b1;
      reh    = rh[0];
      rwrite = 1'b1;
      for (int k = 0; k < asrw_pkg::WINDOW; k++) begin
        if (asrw_pkg::CNT_W'(k) == jj) begin
          na[k] = b_r;
          nh[k] = h_r;
        end else if ((asrw_pkg::CNT_W'(k) < jj) && (k + 1 < asrw_pkg::WINDOW)) begin
          na[k] = ra[(k + 1 < asrw_pkg::WINDOW) ? k + 1 : k];
          nh[k] = rh[(k + 1 < asrw_pkg::WINDOW) ? k + 1 : k];
        end
      end
    end
  end

  // round tick: status of one slot, delivery hit of one position; query acked flag
  always_comb begin
    tcnt  = wcnt_r[cmd.slot];
    tcm1  = tcnt - 1'b1;
    tla   = (tcnt != '0) ? wack_r[cmd.slot][tcm1[asrw_pkg::POS_W-1:0]] : lack_r[cmd.slot];
    tdrop = (tcnt == '0) && asrw_pkg::older(tla + {1'b0, drop_rounds}, seq_r);
    tsus  = !tdrop && asrw_pkg::older(tla + {1'b0, suspend_rounds}, seq_r);
    dhit  = valid_r[cmd.slot] && ({1'b0, cmd.pos} < tcnt);
    qack  = !(slot_ok && valid_r[cl_r] && asrw_pkg::older(lack_r[cl_r], q_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < asrw_pkg::CLIENTS; i++) begin
        valid_r[i] <= 1'b0;
        lack_r[i]  <= 16'd0;
        wcnt_r[i]  <= '0;
      end
      seq_r <= 16'd0;
      ov_r  <= 1'b0;
    end else begin
      if (ov_r && out_ready && !emit) begin
        ov_r <= 1'b0;
      end
      case (cmd.op)
        asrw_pkg::OP_LATCH: begin
          act_r  <= in_action;
          cl_r   <= in_client;
          b_r    <= in_ack_number;
          long_r <= in_long_enough;
          h_r    <= in_handle;
          q_r    <= in_query_number;
        end
        asrw_pkg::OP_EXEC: begin
          ov_r     <= 1'b1;
          o_slot_r <= cl_r;
          o_ph_r   <= 8'd0;
          o_sus_r  <= 1'b0;
          o_drp_r  <= 1'b0;
          o_seq_r  <= seq_r;
          o_last_r <= 1'b1;
          case (act_r)
            asrw_pkg::ACT_RECV: begin
              o_kind_r <= asrw_pkg::KIND_RECV;
              o_code_r <= rcode;
              o_ev_r   <= rev;
              o_eh_r   <= reh;
              o_ack_r  <= 1'b0;
              if (rwrite) begin
                for (int k = 0; k < asrw_pkg::WINDOW; k++) begin
                  wack_r[cl_r][k]  <= na[k];
                  whand_r[cl_r][k] <= nh[k];
                end
              end
              if (rgrow) begin
                wcnt_r[cl_r] <= rcnt + 1'b1;
              end
            end
            asrw_pkg::ACT_JOIN: begin
              o_kind_r <= asrw_pkg::KIND_JOIN;
              o_code_r <= 3'd0;
              o_ev_r   <= 1'b0;
              o_eh_r   <= 8'd0;
              o_ack_r  <= 1'b0;
              if (slot_ok && !valid_r[cl_r]) begin
                valid_r[cl_r] <= 1'b1;
                lack_r[cl_r]  <= seq_r;
                wcnt_r[cl_r]  <= '0;
              end
            end
            asrw_pkg::ACT_LEAVE: begin
              o_kind_r <= asrw_pkg::KIND_JOIN;
              o_code_r <= 3'd0;
              o_ev_r   <= 1'b0;
              o_eh_r   <= 8'd0;
              o_ack_r  <= 1'b0;
              if (slot_ok) begin
                valid_r[cl_r] <= 1'b0;
                wcnt_r[cl_r]  <= '0;
              end
            end
            default: begin
              o_kind_r <= asrw_pkg::KIND_QUERY;
              o_code_r <= 3'd0;
              o_ev_r   <= 1'b0;
              o_eh_r   <= 8'd0;
              o_ack_r  <= qack;
            end
          endcase
        end
        asrw_pkg::OP_TSTAT: begin
          if (valid_r[cmd.slot]) begin
            lack_r[cmd.slot] <= tla;
            if (tdrop) begin
              valid_r[cmd.slot] <= 1'b0;
              wcnt_r[cmd.slot]  <= '0;
            end
            ov_r     <= 1'b1;
            o_kind_r <= asrw_pkg::KIND_STATUS;
            o_slot_r <= cmd.slot;
            o_code_r <= 3'd0;
            o_ph_r   <= 8'd0;
            o_ev_r   <= 1'b0;
            o_eh_r   <= 8'd0;
            o_sus_r  <= tsus;
            o_drp_r  <= tdrop;
            o_ack_r  <= 1'b0;
            o_seq_r  <= seq_r + 16'd1;
            o_last_r <= 1'b0;
          end
        end
        asrw_pkg::OP_TDELIV: begin
          if (dhit) begin
            ov_r     <= 1'b1;
            o_kind_r <= asrw_pkg::KIND_DELIV;
            o_slot_r <= cmd.slot;
            o_code_r <= 3'd0;
            o_ph_r   <= whand_r[cmd.slot][cmd.pos];
            o_ev_r   <= 1'b0;
            o_eh_r   <= 8'd0;
            o_sus_r  <= 1'b0;
            o_drp_r  <= 1'b0;
            o_ack_r  <= 1'b0;
            o_seq_r  <= seq_r + 16'd1;
            o_last_r <= 1'b0;
          end
        end
        asrw_pkg::OP_TDONE: begin
          for (int i = 0; i < asrw_pkg::CLIENTS; i++) begin
            wcnt_r[i] <= '0;
          end
          seq_r    <= seq_r + 16'd1;
          ov_r     <= 1'b1;
          o_kind_r <= asrw_pkg::KIND_ROUND;
          o_slot_r <= 3'd0;
          o_code_r <= 3'd0;
          o_ph_r   <= 8'd0;
          o_ev_r   <= 1'b0;
          o_eh_r   <= 8'd0;
          o_sus_r  <= 1'b0;
          o_drp_r  <= 1'b0;
          o_ack_r  <= 1'b0;
          o_seq_r  <= seq_r + 16'd1;
          o_last_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = o_kind_r;
  assign out_client_slot    = o_slot_r;
  assign out_code           = o_code_r;
  assign out_packet_handle  = o_ph_r;
  assign out_evicted_valid  = o_ev_r;
  assign out_evicted_handle = o_eh_r;
  assign out_suspended      = o_sus_r;
  assign out_dropped        = o_drp_r;
  assign out_acked          = o_ack_r;
  assign out_sequence_res   = o_seq_r;
  assign out_last           = o_last_r;

endmodule

// ----- design/asrw_ctrl.sv -----
// ----------------------------------------------------------------------------
// asrw_ctrl
// sequencer for request handling and the round tick slot walk
// ----------------------------------------------------------------------------
module asrw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  asrw_pkg::sts_t sts,
  output asrw_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TSTAT,
    S_TDELIV,
    S_TDONE
  } state_t;

  state_t                      state_r;
  logic [asrw_pkg::SLOT_W-1:0] i_r;
  logic [asrw_pkg::POS_W-1:0]  j_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd.op   = asrw_pkg::OP_NOP;
    cmd.slot = i_r;
    cmd.pos  = j_r;
    case (state_r)
      S_IDLE:   if (in_valid) cmd.op = asrw_pkg::OP_LATCH;
      S_EXEC: begin
        if (sts.out_free && (sts.action != asrw_pkg::ACT_TICK) &&
            (sts.action <= asrw_pkg::ACT_QUERY)) begin
          cmd.op = asrw_pkg::OP_EXEC;
        end
      end
      S_TSTAT:  if (sts.out_free) cmd.op = asrw_pkg::OP_TSTAT;
      S_TDELIV: if (sts.out_free) cmd.op = asrw_pkg::OP_TDELIV;
      S_TDONE:  if (sts.out_free) cmd.op = asrw_pkg::OP_TDONE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (sts.action == asrw_pkg::ACT_TICK) begin
            state_r <= S_TSTAT;
            i_r     <= '0;
            j_r     <= '0;
          end else if (sts.action > asrw_pkg::ACT_QUERY) begin
            state_r <= S_IDLE;
          end else if (sts.out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_TSTAT: begin
          if (sts.out_free) begin
            if (i_r == asrw_pkg::SLOT_W'(asrw_pkg::CLIENTS - 1)) begin
              i_r     <= '0;
              state_r <= S_TDELIV;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_TDELIV: begin
          if (sts.out_free) begin
            if (i_r == asrw_pkg::SLOT_W'(asrw_pkg::CLIENTS - 1)) begin
              i_r <= '0;
              if (j_r == asrw_pkg::POS_W'(asrw_pkg::WINDOW - 1)) begin
                j_r     <= '0;
                state_r <= S_TDONE;
              end else begin
                j_r <= j_r + 1'b1;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        S_TDONE: begin
          if (sts.out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/ack_sequence_reorder_window_top.sv -----
// ----------------------------------------------------------------------------
// ack_sequence_reorder_window_top
// per-client reorder window with round ticks and register port
// ----------------------------------------------------------------------------
// request flow: receive, join, leave and query are latched when taken; the exec
//   step then loads the result into the output register, waiting while that
//   register is stalled, and only then is the next request taken
// round tick: status of each joined slot, then delivery for each window position
//   and slot, then round done; each step waits while the output register is stalled
// reset: synchronous active low; all clients left, sequence 0, registers 20/1200
module ack_sequence_reorder_window_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // client, ack_number, long_enough, handle, query_number
  input  logic [2:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  // client_slot, code, packet_handle, evicted_valid, evicted_handle, suspended,
  // dropped, acked, sequence_res
  output logic [47:0] out_tdata,
  output logic [2:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [14:0] susp_r;
  logic [14:0] drop_r;
  logic        cfg_wr;

  asrw_pkg::cmd_t cmd;
  asrw_pkg::sts_t sts;

  logic [2:0]  o_slot, o_code;
  logic [7:0]  o_ph, o_eh;
  logic        o_ev, o_sus, o_drp, o_ack;
  logic [15:0] o_seq;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == asrw_pkg::REG_DROP) ? {17'd0, drop_r} : {17'd0, susp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      susp_r <= asrw_pkg::SUSPEND_RESET;
      drop_r <= asrw_pkg::DROP_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == asrw_pkg::REG_DROP) begin
        drop_r <= cfg_pwdata[14:0];
      end else begin
        susp_r <= cfg_pwdata[14:0];
      end
    end
  end

  asrw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  asrw_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_action          (in_tuser),
    .in_client          (in_tdata[2:0]),
    .in_ack_number      (in_tdata[18:3]),
    .in_long_enough     (in_tdata[19]),
    .in_handle          (in_tdata[27:20]),
    .in_query_number    (in_tdata[43:28]),
    .suspend_rounds     (susp_r),
    .drop_rounds        (drop_r),
    .out_ready          (out_tready),
    .out_valid          (out_tvalid),
    .out_kind           (out_tuser),
    .out_client_slot    (o_slot),
    .out_code           (o_code),
    .out_packet_handle  (o_ph),
    .out_evicted_valid  (o_ev),
    .out_evicted_handle (o_eh),
    .out_suspended      (o_sus),
    .out_dropped        (o_drp),
    .out_acked          (o_ack),
    .out_sequence_res   (o_seq),
    .out_last           (out_tlast)
  );

  assign out_tdata = {6'd0, o_seq, o_ack, o_drp, o_sus, o_eh, o_ev, o_ph, o_code, o_slot};

`include "ack_sequence_reorder_window_top_assert.svh"

  `ASRW_ASSERT_NOW(a_emit_free, (cmd.op == asrw_pkg::OP_EXEC || cmd.op == asrw_pkg::OP_TSTAT || cmd.op == asrw_pkg::OP_TDELIV || cmd.op == asrw_pkg::OP_TDONE), sts.out_free, "result issued while output register occupied")
  `ASRW_ASSERT_NEXT(a_busy_after_take, (in_tvalid && in_tready), !in_tready, "request taken while previous one in progress")
  `ASRW_ASSERT_NOW(a_join_last, (out_tvalid && out_tuser == asrw_pkg::KIND_JOIN), out_tlast, "join or leave result not marked last")

endmodule
